/* hw/rtl/cobs_dec_pkg.sv */
// Types and status codes shared by the COBS frame decoder modules.
package cobs_dec_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 7;

   localparam logic [BYTE_W-1:0] CODE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] CODE_FULL = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_CODE = 3'd1,
      ST_TRUNC     = 3'd2,
      ST_FULL_MID  = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              frame_done;
      logic [2:0]        frame_status;
      logic [LEN_W-1:0]  frame_length;
   } rsp_type;

   // Input register contents handed to the decode step.
   typedef struct packed {
      logic    valid;
      req_type beat;
   } stage_type;

endpackage

/* hw/rtl/cobs_dec_chan_if.sv */
// Valid/ready channel carrying one beat of a given payload type.
interface cobs_dec_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/cobs_dec_in_reg.sv */
// Input register: captures one encoded beat and holds it until the step takes it.
module cobs_dec_in_reg
   import cobs_dec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  req_type   req_beat,
   output logic      req_ready,
   input  logic      advance,
   output stage_type stage
);

   logic    valid_ff, valid_in;
   req_type beat_ff, beat_in;
   logic    take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (take) begin
         valid_in = 1'b1;
         beat_in  = req_beat;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign stage.valid = valid_ff;
   assign stage.beat  = beat_ff;

endmodule

/* hw/rtl/cobs_dec_step.sv */
// Decode step: frame state registers and the per-byte decode logic.
module cobs_dec_step
   import cobs_dec_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 64
)(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   input  logic      advance,
   output rsp_type   result
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

   logic [BYTE_W-1:0] group_left_ff, group_left_in;
   logic              prev_full_ff, prev_full_in;
   logic              at_start_ff, at_start_in;
   status_type        error_ff, error_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              full;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic [CNT_W+LEN_W-1:0] count_ext;

   assign full = (count_ff >= CNT_W'(MAX_FRAME));

   always_comb begin
      group_left_in = group_left_ff;
      prev_full_in  = prev_full_ff;
      at_start_in   = at_start_ff;
      error_in      = error_ff;
      count_in      = count_ff;
      emit          = 1'b0;
      emit_byte     = CODE_ZERO;

      if (error_ff == ST_OK) begin
         if (group_left_ff == '0) begin
            // Code byte: close the previous group first.
            if (!at_start_ff) begin
               if (prev_full_ff) begin
                  error_in = ST_FULL_MID;
               end else if (full) begin
                  error_in = ST_TOO_LONG;
               end else begin
                  emit     = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            if (error_in == ST_OK) begin
               if (stage.beat.in_byte == CODE_ZERO) begin
                  error_in = ST_ZERO_CODE;
               end else begin
                  group_left_in = stage.beat.in_byte - 1'b1;
                  prev_full_in  = (stage.beat.in_byte == CODE_FULL);
               end
            end
            at_start_in = 1'b0;
         end else begin
            group_left_in = group_left_ff - 1'b1;
            if (full) begin
               error_in = ST_TOO_LONG;
            end else begin
               emit      = 1'b1;
               emit_byte = stage.beat.in_byte;
               count_in  = count_ff + 1'b1;
            end
         end
      end

      if (stage.beat.in_last && error_in == ST_OK && group_left_in != '0) begin
         error_in = ST_TRUNC;
      end
   end

   assign count_ext = {{LEN_W{1'b0}}, count_in};

   always_comb begin
      result.out_valid    = emit;
      result.out_byte     = emit_byte;
      result.frame_done   = stage.beat.in_last;
      result.frame_status = stage.beat.in_last ? error_in : ST_OK;
      result.frame_length = stage.beat.in_last ? count_ext[LEN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_left_ff <= '0;
         prev_full_ff  <= 1'b0;
         at_start_ff   <= 1'b1;
         error_ff      <= ST_OK;
         count_ff      <= '0;
      end else if (advance) begin
         if (stage.beat.in_last) begin
            // Frame end: drop all frame state.
            group_left_ff <= '0;
            prev_full_ff  <= 1'b0;
            at_start_ff   <= 1'b1;
            error_ff      <= ST_OK;
            count_ff      <= '0;
         end else begin
            group_left_ff <= group_left_in;
            prev_full_ff  <= prev_full_in;
            at_start_ff   <= at_start_in;
            error_ff      <= error_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

/* hw/rtl/cobs_dec_out_reg.sv */
// Result register: holds one decoded beat until the sink takes it.
module cobs_dec_out_reg
   import cobs_dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    stage_valid,
   input  rsp_type result,
   output logic    advance,
   output logic    rsp_valid,
   output rsp_type rsp_beat,
   input  logic    rsp_ready
);

   logic    valid_ff, valid_in;
   rsp_type beat_ff, beat_in;

   assign advance = stage_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (advance) begin
         valid_in = 1'b1;
         beat_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

/* hw/rtl/cobs_frame_decoder.sv */
// COBS frame decoder top level: input register, decode step, result register.
//
//   channel    dir  payload                                          beat
//   req_chan   in   in_byte, in_last                                 one encoded byte
//   rsp_chan   out  out_valid, out_byte, frame_done, frame_status,   one per req beat
//                   frame_length
//
// One beat per cycle while rsp_chan is ready; beats pass the input then the result register.
// The frame state register updates once per beat, which bounds the rate.
// Synchronous reset empties both registers and returns to frame start.
// A stalled rsp_chan holds the result; the input register still takes one more beat.
module cobs_frame_decoder
   import cobs_dec_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 64
)(
   input  logic clock,
   input  logic reset,
   cobs_dec_chan_if.sink   req_chan,
   cobs_dec_chan_if.source rsp_chan
);

   stage_type stage;
   rsp_type   result;
   rsp_type   rsp_beat;
   logic      advance;

   cobs_dec_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_beat  (req_chan.payload),
      .req_ready (req_chan.ready),
      .advance   (advance),
      .stage     (stage)
   );

   cobs_dec_step #(
      .MAX_FRAME (MAX_FRAME)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   cobs_dec_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage.valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_chan.valid),
      .rsp_beat    (rsp_beat),
      .rsp_ready   (rsp_chan.ready)
   );

   assign rsp_chan.payload = rsp_beat;

`ifndef SYNTH
   // A beat in the input register is never dropped while the result side stalls.
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      stage.valid && !advance |=> stage.valid)
      else $error("input beat lost while stalled");

   // Status and length are only reported on the frame's last beat.
   a_mid_frame_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_beat.frame_done |->
         rsp_beat.frame_status == ST_OK && rsp_beat.frame_length == '0)
      else $error("status or length reported mid-frame");

   // A suppressed byte reads as zero.
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_beat.out_valid |-> rsp_beat.out_byte == CODE_ZERO)
      else $error("out_byte nonzero without out_valid");
`endif

endmodule

/* dv/cobs_frame_decoder_test.sv */
// Self-checking testbench for the COBS frame decoder: directed table, random frames, stalls.
module cobs_frame_decoder_test;
   import cobs_dec_pkg::*;

   localparam int unsigned MAX_FRAME    = 64;
   localparam int          RANDOM_BEATS = 1450;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 8;

   typedef enum int {
      FR_CLEAN,
      FR_FULL_GROUP,
      FR_BROKEN,
      FR_NOISE,
      FR_AT_LIMIT
   } frame_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] code_or_data;
      logic              last;
      logic              typed;
      rsp_type           want;
   } dir_row_type;

   // Rows with typed=1 carry the expected frame-end result, worked out by hand.
   localparam dir_row_type DIR_ROWS [25] = '{
      '{8'h01, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_OK,        7'd0}},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, ST_OK,        7'd2}},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_ZERO_CODE, 7'd0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      '{8'h11, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, ST_ZERO_CODE, 7'd0}},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'hC3, 1'b0, 1'b0, '0},
      '{8'h3C, 1'b1, 1'b1, '{1'b1, 8'h3C, 1'b1, ST_TRUNC,     7'd2}},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, ST_ZERO_CODE, 7'd2}},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h11, 1'b0, 1'b0, '0},
      '{8'h22, 1'b1, 1'b1, '{1'b1, 8'h22, 1'b1, ST_TRUNC,     7'd2}},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, ST_OK,        7'd1}}
   };

   logic clock = 1'b0;
   logic reset;

   cobs_dec_chan_if #(.payload_type(req_type)) req_chan ();
   cobs_dec_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   cobs_frame_decoder #(.MAX_FRAME(MAX_FRAME)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Decoder state mirror
   logic [BYTE_W-1:0] dec_left;
   logic              dec_prev_full;
   logic              dec_first;
   status_type        dec_err;
   logic [LEN_W-1:0]  dec_count;

   rsp_type           decoded_q [$];
   logic [BYTE_W-1:0] plain_q [$];
   logic [BYTE_W-1:0] coded_q [$];

   logic    note_typed = 1'b0;
   rsp_type note_want  = '0;
   bit      idle_on    = 1'b1;
   int      hold_req   = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   int      beats_sent  = 0;
   int      frames_done = 0;
   int      bytes_out   = 0;
   int      status_seen [5] = '{default: 0};

   function automatic void clear_decoder();
      dec_left      = '0;
      dec_prev_full = 1'b0;
      dec_first     = 1'b1;
      dec_err       = ST_OK;
      dec_count     = '0;
   endfunction

   function automatic rsp_type decode_byte(input logic [BYTE_W-1:0] b, input logic last);
      rsp_type r;
      r = '0;
      if (dec_err == ST_OK) begin
         if (dec_left == 0) begin
            // code byte: close the previous group first
            if (!dec_first) begin
               if (dec_prev_full) begin
                  dec_err = ST_FULL_MID;
               end else if (dec_count >= MAX_FRAME) begin
                  dec_err = ST_TOO_LONG;
               end else begin
                  r.out_valid = 1'b1;
                  r.out_byte  = CODE_ZERO;
                  dec_count   = dec_count + 1'b1;
               end
            end
            if (dec_err == ST_OK) begin
               if (b == CODE_ZERO) begin
                  dec_err = ST_ZERO_CODE;
               end else begin
                  dec_left      = b - 1'b1;
                  dec_prev_full = (b == CODE_FULL);
               end
            end
            dec_first = 1'b0;
         end else begin
            dec_left = dec_left - 1'b1;
            if (dec_count >= MAX_FRAME) begin
               dec_err = ST_TOO_LONG;
            end else begin
               r.out_valid = 1'b1;
               r.out_byte  = b;
               dec_count   = dec_count + 1'b1;
            end
         end
      end
      if (last) begin
         if (dec_err == ST_OK && dec_left != 0)
            dec_err = ST_TRUNC;
         r.frame_done   = 1'b1;
         r.frame_status = dec_err;
         r.frame_length = dec_count;
         clear_decoder();
      end
      return r;
   endfunction

   initial clear_decoder();

   always @(posedge clock) begin : predict_beat
      rsp_type p;
      if (!reset && req_chan.valid && req_chan.ready) begin
         p = decode_byte(req_chan.payload.in_byte, req_chan.payload.in_last);
         decoded_q.push_back(note_typed ? note_want : p);
      end
   end

   always @(posedge clock) begin : check_beat
      rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (decoded_q.size() == 0) begin
            $error("unexpected result beat %h", got);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            if (got.out_valid !== want.out_valid) begin
               $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
               error_count++;
            end
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
               error_count++;
            end
            if (got.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
               error_count++;
            end
            if (got.frame_status !== want.frame_status) begin
               $error("frame_status: expected %0d, got %0d",
                      want.frame_status, got.frame_status);
               error_count++;
            end
            if (got.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, got.frame_length);
               error_count++;
            end
         end
         if (got.out_valid === 1'b1)
            bytes_out++;
         if (got.frame_done === 1'b1) begin
            frames_done++;
            if (got.frame_status < 5)
               status_seen[got.frame_status]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall bursts, long hold-off on request, else ready when idling is off.
   initial begin : rsp_side
      int stall_left, run_left, hold_left;
      stall_left = 0;
      run_left   = 0;
      hold_left  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (!idle_on) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (run_left != 0) begin
            rsp_chan.ready <= 1'b1;
            run_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            run_left = $urandom_range(1, 40) - 1;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Enter and leave at a falling edge.
   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last,
                            input logic typed, input rsp_type want);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      note_typed = typed;
      note_want  = want;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{in_byte: b, in_last: last};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (decoded_q.size() != 0);
   endtask

   function automatic void cobs_encode();
      int code, code_at;
      coded_q.delete();
      code    = 1;
      code_at = 0;
      coded_q.push_back(8'h00);
      foreach (plain_q[i]) begin
         if (plain_q[i] == CODE_ZERO) begin
            coded_q[code_at] = 8'(code);
            code_at = coded_q.size();
            coded_q.push_back(8'h00);
            code = 1;
         end else begin
            coded_q.push_back(plain_q[i]);
            code++;
            if (code == CODE_FULL) begin
               coded_q[code_at] = 8'(code);
               code_at = coded_q.size();
               coded_q.push_back(8'h00);
               code = 1;
            end
         end
      end
      coded_q[code_at] = 8'(code);
   endfunction

   function automatic void fill_plain(input int len, input int zero_odds);
      plain_q.delete();
      repeat (len)
         plain_q.push_back($urandom_range(0, zero_odds) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
   endfunction

   function automatic frame_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return FR_CLEAN;
      if (roll < 68) return FR_FULL_GROUP;
      if (roll < 80) return FR_BROKEN;
      if (roll < 90) return FR_NOISE;
      return FR_AT_LIMIT;
   endfunction

   function automatic void build_frame(input frame_kind_type kind);
      int n;
      case (kind)
         FR_CLEAN: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 72) : $urandom_range(0, 24);
            fill_plain(n, 3);
            cobs_encode();
         end
         // A full group overruns the frame limit before it ends, so short ones truncate
         // and long ones run past the limit.
         FR_FULL_GROUP: begin
            coded_q.delete();
            coded_q.push_back(CODE_FULL);
            repeat ($urandom_range(0, 72)) coded_q.push_back(8'($urandom_range(0, 255)));
         end
         FR_BROKEN: begin
            fill_plain($urandom_range(1, 30), 3);
            cobs_encode();
            if ($urandom_range(0, 1) == 0) begin
               n = $urandom_range(1, coded_q.size());
               while (coded_q.size() > n) void'(coded_q.pop_back());
            end else begin
               coded_q[$urandom_range(0, coded_q.size() - 1)] = 8'h00;
            end
         end
         FR_NOISE: begin
            coded_q.delete();
            repeat ($urandom_range(1, 10))
               coded_q.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
         end
         default: begin
            // land right around the limit, at a code byte or a data byte
            fill_plain($urandom_range(MAX_FRAME - 2, MAX_FRAME + 2), 7);
            cobs_encode();
         end
      endcase
   endfunction

   task automatic send_frame();
      foreach (coded_q[i])
         send_beat(coded_q[i], i == coded_q.size() - 1, 1'b0, '0);
   endtask

   initial begin : stimulus
      int frame_no;
      int rand_start;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i])
         send_beat(DIR_ROWS[i].code_or_data, DIR_ROWS[i].last,
                   DIR_ROWS[i].typed, DIR_ROWS[i].want);
      pause_until_drained();

      // hold the result side while beats keep coming, so the input stalls
      hold_req = 60;
      build_frame(FR_AT_LIMIT);
      send_frame();
      pause_until_drained();

      rand_start = beats_sent;
      frame_no   = 0;
      while (beats_sent - rand_start < RANDOM_BEATS) begin
         idle_on = (beats_sent - rand_start < RANDOM_BEATS - 150) && (frame_no % 9 != 4);
         if (frame_no == 30)
            hold_req = 45;
         if (frame_no % 40 == 39)
            pause_until_drained();
         build_frame(frame_no < 5 ? frame_kind_type'(frame_no) : pick_kind());
         send_frame();
         frame_no++;
      end
      req_chan.valid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d encoded beats, %0d frames, %0d decoded bytes.",
               beats_sent, frames_done, bytes_out);
      $display("Frame status: ok %0d, zero code %0d, truncated %0d, full mid %0d, too long %0d",
               status_seen[ST_OK], status_seen[ST_ZERO_CODE], status_seen[ST_TRUNC],
               status_seen[ST_FULL_MID], status_seen[ST_TOO_LONG]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
